// ===== rtl/bmb_pkg.sv =====
// ----------------------------------------------------------------------------
// bmb_pkg
// Shared constants, types and register indexes for the box mean blur block.
// ----------------------------------------------------------------------------
package bmb_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int MaxRadius  = 7;

    localparam int ColW       = 8;
    localparam int RowW       = 8;
    localparam int LevelW     = 8;
    localparam int DimW       = 9;
    localparam int RadW       = 3;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 9;

    localparam int StoreDepth = MaxWidth * MaxHeight;
    localparam int AddrW      = $clog2(StoreDepth);
    localparam int WinMax     = (2 * MaxRadius + 1) * (2 * MaxRadius + 1);
    localparam int SumW       = $clog2(WinMax * (2 ** LevelW - 1) + 1);
    localparam int CntW       = $clog2(WinMax + 1);
    localparam int StepW      = $clog2(SumW + 1);

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);

    localparam logic [CfgIndexW-1:0] RegFrameWidth  = 2'd0;
    localparam logic [CfgIndexW-1:0] RegFrameHeight = 2'd1;
    localparam logic [CfgIndexW-1:0] RegRadiusX     = 2'd2;
    localparam logic [CfgIndexW-1:0] RegRadiusY     = 2'd3;

    localparam logic CmdStore = 1'b0;
    localparam logic CmdRead  = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_ZERO
    } t_kind;

    // One classified item. A write uses x_lo and y_lo as its address.
    typedef struct packed {
        t_kind               kind;
        logic [LevelW-1:0]   level;
        logic [ColW-1:0]     x_lo;
        logic [ColW-1:0]     x_hi;
        logic [RowW-1:0]     y_lo;
        logic [RowW-1:0]     y_hi;
    } t_op;

    typedef struct packed {
        logic push;
        t_op  op;
    } t_push;

endpackage

// ===== rtl/box_mean_blur_edge_clipped.sv =====
// ----------------------------------------------------------------------------
// box_mean_blur_edge_clipped
// Grey frame store with a box-mean read port.
//
// Input items arrive on the s_axis channel: tuser is the command (store or
// read), tdata carries column, row and grey level. A store writes one pixel;
// a store outside the frame is dropped. A read returns one item on m_axis
// with the truncated mean of the window pixels that lie inside the frame, or
// zero when the center lies outside the frame. Configuration registers are
// written through the cfg port only while the block is idle; the user must
// keep to this, the block does not enforce it. The front classifies items
// and clips the window; a four-entry queue holds them for the back, which
// owns the frame store. A read walks its window one pixel per cycle from
// the store read port, then runs a 16-step serial divider. Items are taken
// while the queue has room, also while a result waits.
// Synchronous reset sets width and height to 256 and both radii to 1 and
// empties the queue; the store contents stay undefined until written.
// A stalled receiver holds the result register; the back stops at the next
// read result or out-of-frame read, while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module box_mean_blur_edge_clipped (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmb_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [bmb_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // col, row, level
    input  logic                           s_axis_tuser,  // command
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata   // mean_level
);

    bmb_pkg::t_push push;
    bmb_pkg::t_op   head;
    logic           queue_full;
    logic           queue_empty;
    logic           pop;

    bmb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_command    (s_axis_tuser),
        .i_col        (s_axis_tdata[7:0]),
        .i_row        (s_axis_tdata[15:8]),
        .i_level      (s_axis_tdata[23:16]),
        .i_queue_full (queue_full),
        .o_ready      (s_axis_tready),
        .o_push       (push)
    );

    bmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head)
    );

    bmb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_level (m_axis_tdata)
    );

endmodule

// ===== rtl/bmb_front.sv =====
// ----------------------------------------------------------------------------
// bmb_front
// Holds the configuration, accepts items, drops writes outside the frame and
// works out the clipped window bounds of each read.
// ----------------------------------------------------------------------------
module bmb_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmb_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [bmb_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_command,
    input  logic [bmb_pkg::ColW-1:0]       i_col,
    input  logic [bmb_pkg::RowW-1:0]       i_row,
    input  logic [bmb_pkg::LevelW-1:0]     i_level,
    input  logic                           i_queue_full,
    output logic                           o_ready,
    output bmb_pkg::t_push                 o_push
);

    logic [bmb_pkg::DimW-1:0] r_frame_width;
    logic [bmb_pkg::DimW-1:0] r_frame_height;
    logic [bmb_pkg::RadW-1:0] r_radius_x;
    logic [bmb_pkg::RadW-1:0] r_radius_y;

    logic [bmb_pkg::DimW-1:0] w;
    logic [bmb_pkg::DimW-1:0] h;
    logic [bmb_pkg::RadW-1:0] rx;
    logic [bmb_pkg::RadW-1:0] ry;
    logic                     in_frame;
    logic [bmb_pkg::DimW-1:0] x_end;
    logic [bmb_pkg::DimW-1:0] y_end;
    logic [bmb_pkg::DimW-1:0] x_max;
    logic [bmb_pkg::DimW-1:0] y_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bmb_pkg::DimW'(256);
            r_frame_height <= bmb_pkg::DimW'(256);
            r_radius_x     <= bmb_pkg::RadW'(1);
            r_radius_y     <= bmb_pkg::RadW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmb_pkg::RegFrameWidth:  r_frame_width  <= i_cfg_data;
                bmb_pkg::RegFrameHeight: r_frame_height <= i_cfg_data;
                bmb_pkg::RegRadiusX:     r_radius_x     <= i_cfg_data[bmb_pkg::RadW-1:0];
                bmb_pkg::RegRadiusY:     r_radius_y     <= i_cfg_data[bmb_pkg::RadW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w  = (r_frame_width > bmb_pkg::DimW'(bmb_pkg::MaxWidth))
             ? bmb_pkg::DimW'(bmb_pkg::MaxWidth) : r_frame_width;
        h  = (r_frame_height > bmb_pkg::DimW'(bmb_pkg::MaxHeight))
             ? bmb_pkg::DimW'(bmb_pkg::MaxHeight) : r_frame_height;
        rx = (r_radius_x > bmb_pkg::RadW'(bmb_pkg::MaxRadius))
             ? bmb_pkg::RadW'(bmb_pkg::MaxRadius) : r_radius_x;
        ry = (r_radius_y > bmb_pkg::RadW'(bmb_pkg::MaxRadius))
             ? bmb_pkg::RadW'(bmb_pkg::MaxRadius) : r_radius_y;

        in_frame = (bmb_pkg::DimW'(i_col) < w) && (bmb_pkg::DimW'(i_row) < h);

        // The window is clipped to the frame, so the pixel count is its area.
        x_end = bmb_pkg::DimW'(i_col) + bmb_pkg::DimW'(rx);
        y_end = bmb_pkg::DimW'(i_row) + bmb_pkg::DimW'(ry);
        x_max = w - 1'b1;
        y_max = h - 1'b1;

        o_push.op.level = i_level;
        o_push.op.x_lo  = i_col;
        o_push.op.x_hi  = i_col;
        o_push.op.y_lo  = i_row;
        o_push.op.y_hi  = i_row;
        o_push.op.kind  = bmb_pkg::KIND_WRITE;
        if (i_command == bmb_pkg::CmdRead) begin
            if (in_frame) begin
                o_push.op.kind = bmb_pkg::KIND_READ;
                o_push.op.x_lo = (i_col >= bmb_pkg::ColW'(rx))
                                 ? i_col - bmb_pkg::ColW'(rx) : '0;
                o_push.op.y_lo = (i_row >= bmb_pkg::RowW'(ry))
                                 ? i_row - bmb_pkg::RowW'(ry) : '0;
                o_push.op.x_hi = (x_end > x_max) ? x_max[bmb_pkg::ColW-1:0]
                                                 : x_end[bmb_pkg::ColW-1:0];
                o_push.op.y_hi = (y_end > y_max) ? y_max[bmb_pkg::RowW-1:0]
                                                 : y_end[bmb_pkg::RowW-1:0];
            end else begin
                o_push.op.kind = bmb_pkg::KIND_ZERO;
            end
        end

        o_ready     = !i_queue_full;
        o_push.push = i_valid && !i_queue_full
                      && (i_command == bmb_pkg::CmdRead || in_frame);
    end

endmodule

// ===== rtl/bmb_queue.sv =====
// ----------------------------------------------------------------------------
// bmb_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bmb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmb_pkg::t_push    i_push,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output bmb_pkg::t_op      o_head
);

    bmb_pkg::t_op                 r_slot [bmb_pkg::QueueDepth];
    logic [bmb_pkg::QPtrW-1:0]    r_wr_ptr;
    logic [bmb_pkg::QPtrW-1:0]    r_rd_ptr;
    logic [bmb_pkg::QPtrW:0]      r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push.push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push.push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wr_ptr] <= i_push.op;
        end
    end

    assign o_full  = (r_fill == (bmb_pkg::QPtrW + 1)'(bmb_pkg::QueueDepth));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slot[r_rd_ptr];

endmodule

// ===== rtl/bmb_back.sv =====
// ----------------------------------------------------------------------------
// bmb_back
// Owns the frame store. Carries out writes, walks read windows one pixel a
// cycle, divides the sum by the count bit-serially and holds the result.
// ----------------------------------------------------------------------------
module bmb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  bmb_pkg::t_op                 i_head,
    output logic                         o_pop,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [bmb_pkg::LevelW-1:0]   o_out_level
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                         r_state;
    bmb_pkg::t_op                   r_op;
    logic [bmb_pkg::ColW-1:0]       r_x;
    logic [bmb_pkg::RowW-1:0]       r_y;
    logic                           r_pend;
    logic [bmb_pkg::SumW-1:0]       r_sum;
    logic [bmb_pkg::CntW-1:0]       r_count;
    logic [bmb_pkg::CntW-1:0]       r_rem;
    logic [bmb_pkg::StepW-1:0]      r_step;
    logic                           r_out_valid;
    logic [bmb_pkg::LevelW-1:0]     r_out_level;

    logic [bmb_pkg::LevelW-1:0]     r_mem [bmb_pkg::StoreDepth];
    logic [bmb_pkg::LevelW-1:0]     r_rd_data;

    logic                           out_free;
    logic                           out_load;
    logic                           mem_we;
    logic [bmb_pkg::AddrW-1:0]      wr_addr;
    logic [bmb_pkg::AddrW-1:0]      rd_addr;
    logic [bmb_pkg::CntW:0]         rem_sh;
    logic                           rem_ge;
    logic [bmb_pkg::CntW:0]         rem_nx;

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        o_pop    = (r_state == ST_IDLE) && !i_empty
                   && (i_head.kind != bmb_pkg::KIND_ZERO || out_free);
        out_load = (o_pop && i_head.kind == bmb_pkg::KIND_ZERO)
                   || (r_state == ST_DONE && out_free);
        mem_we   = o_pop && (i_head.kind == bmb_pkg::KIND_WRITE);
        wr_addr  = bmb_pkg::AddrW'(i_head.y_lo) * bmb_pkg::AddrW'(bmb_pkg::MaxWidth)
                   + bmb_pkg::AddrW'(i_head.x_lo);
        rd_addr  = bmb_pkg::AddrW'(r_y) * bmb_pkg::AddrW'(bmb_pkg::MaxWidth)
                   + bmb_pkg::AddrW'(r_x);
        rem_sh   = {r_rem, r_sum[bmb_pkg::SumW-1]};
        rem_ge   = rem_sh >= {1'b0, r_count};
        rem_nx   = rem_ge ? rem_sh - {1'b0, r_count} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_head.level;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == ST_WALK);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_pend) begin
                r_sum   <= r_sum + bmb_pkg::SumW'(r_rd_data);
                r_count <= r_count + 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && i_head.kind == bmb_pkg::KIND_ZERO) begin
                        r_out_level <= '0;
                    end else if (o_pop && i_head.kind == bmb_pkg::KIND_READ) begin
                        r_op    <= i_head;
                        r_x     <= i_head.x_lo;
                        r_y     <= i_head.y_lo;
                        r_sum   <= '0;
                        r_count <= '0;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (r_x == r_op.x_hi) begin
                        r_x <= r_op.x_lo;
                        if (r_y == r_op.y_hi) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_y <= r_y + 1'b1;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_rem   <= '0;
                    r_step  <= bmb_pkg::StepW'(bmb_pkg::SumW);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem  <= rem_nx[bmb_pkg::CntW-1:0];
                    r_sum  <= {r_sum[bmb_pkg::SumW-2:0], rem_ge};
                    r_step <= r_step - 1'b1;
                    if (r_step == bmb_pkg::StepW'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_level <= r_sum[bmb_pkg::LevelW-1:0];
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_level = r_out_level;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Box mean blur testbench
// Streams pixel stores and window-mean reads into the block and checks every
// returned mean against a predictor that keeps its own copy of the frame
// store and the frame and radius registers. Reads are only issued once every
// in-frame pixel of their window has been stored. The run walks through
// directed corner cases, fills a patch near the origin and then runs a series
// of randomly configured phases around that patch, with random gaps on both
// sides of the block in all phases but one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int StallLimit = 5000;
    localparam int SettleCycles = 32;
    localparam int RandomPhases = 6;
    localparam int OpsPerPhase = 28;
    localparam int HotSpan = 7;

    typedef struct packed {
        logic                       cmd;
        logic [bmb_pkg::LevelW-1:0] level;
        logic [bmb_pkg::RowW-1:0]   row;
        logic [bmb_pkg::ColW-1:0]   col;
    } t_pixel_cmd;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [bmb_pkg::CfgIndexW-1:0] i_cfg_index = bmb_pkg::RegFrameWidth;
    logic [bmb_pkg::CfgDataW-1:0]  i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [23:0]                   s_axis_tdata = '0;  // col, row, level
    logic                          s_axis_tuser = bmb_pkg::CmdStore;  // command
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;  // mean_level

    logic [bmb_pkg::DimW-1:0]   width_reg = 9'd256;
    logic [bmb_pkg::DimW-1:0]   height_reg = 9'd256;
    logic [bmb_pkg::RadW-1:0]   radius_x_reg = 3'd1;
    logic [bmb_pkg::RadW-1:0]   radius_y_reg = 3'd1;

    logic [bmb_pkg::LevelW-1:0] pix_mem [bmb_pkg::StoreDepth];
    bit                         filled [bmb_pkg::StoreDepth];

    t_pixel_cmd        cmd_backlog [$];
    logic [7:0]        mean_backlog [$];
    t_pixel_cmd        drv_item;
    logic [7:0]        want_mean;
    int                mismatch_cnt = 0;
    int                stall_cycles = 0;
    bit                calm = 1'b0;

    box_mean_blur_edge_clipped u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit on_frame(int x, int y);
        int w;
        int h;
        w = (width_reg > bmb_pkg::MaxWidth) ? bmb_pkg::MaxWidth : int'(width_reg);
        h = (height_reg > bmb_pkg::MaxHeight) ? bmb_pkg::MaxHeight : int'(height_reg);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    function automatic logic [7:0] window_mean(int cx, int cy);
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        if (!on_frame(cx, cy)) return 8'd0;
        for (int y = cy - int'(radius_y_reg); y <= cy + int'(radius_y_reg); y++) begin
            for (int x = cx - int'(radius_x_reg); x <= cx + int'(radius_x_reg); x++) begin
                if (on_frame(x, y)) begin
                    sum += pix_mem[y * bmb_pkg::MaxWidth + x];
                    cnt++;
                end
            end
        end
        return (cnt == 0) ? 8'd0 : 8'(sum / cnt);
    endfunction

    task automatic add_store(int c, int r, logic [7:0] lvl);
        t_pixel_cmd it;
        it.cmd = bmb_pkg::CmdStore;
        it.col = 8'(c);
        it.row = 8'(r);
        it.level = lvl;
        cmd_backlog.push_back(it);
        if (on_frame(c, r)) filled[r * bmb_pkg::MaxWidth + c] = 1'b1;
    endtask

    // Any in-frame window pixel that was never stored gets a random level first.
    task automatic add_read(int c, int r);
        t_pixel_cmd it;
        if (on_frame(c, r)) begin
            for (int y = r - int'(radius_y_reg); y <= r + int'(radius_y_reg); y++) begin
                for (int x = c - int'(radius_x_reg); x <= c + int'(radius_x_reg); x++) begin
                    if (on_frame(x, y) && !filled[y * bmb_pkg::MaxWidth + x])
                        add_store(x, y, 8'($urandom_range(255)));
                end
            end
        end
        it.cmd = bmb_pkg::CmdRead;
        it.col = 8'(c);
        it.row = 8'(r);
        it.level = 8'($urandom_range(255));
        cmd_backlog.push_back(it);
    endtask

    task automatic set_reg(logic [bmb_pkg::CfgIndexW-1:0] idx,
                           logic [bmb_pkg::CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bmb_pkg::RegFrameWidth:  width_reg = data;
            bmb_pkg::RegFrameHeight: height_reg = data;
            bmb_pkg::RegRadiusX:     radius_x_reg = data[bmb_pkg::RadW-1:0];
            bmb_pkg::RegRadiusY:     radius_y_reg = data[bmb_pkg::RadW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (cmd_backlog.size() != 0 || s_axis_tvalid || mean_backlog.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    function automatic logic [bmb_pkg::CfgDataW-1:0] pick_dim();
        case ($urandom_range(9))
            0: return 9'd1;
            1: return 9'd256;
            2: return 9'($urandom_range(511, 257));
            3: return 9'd0;
            default: return 9'($urandom_range(256, 1));
        endcase
    endfunction

    initial begin
        int c;
        int r;
        int k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_store(0, 0, 8'hFF);
        add_store(1, 0, 8'h00);
        add_store(0, 1, 8'hFF);
        add_store(1, 1, 8'hFE);
        add_read(0, 0);
        add_store(255, 255, 8'h01);
        add_read(255, 255);
        add_store(128, 64, 8'hAA);
        add_read(128, 64);
        add_read(0, 255);
        drain();

        set_reg(bmb_pkg::RegFrameWidth, 9'd1);
        set_reg(bmb_pkg::RegFrameHeight, 9'd1);
        add_read(0, 0);
        add_store(0, 0, 8'h7F);
        add_read(0, 0);
        add_store(1, 0, 8'h33);
        add_read(1, 0);
        add_read(0, 1);
        drain();

        set_reg(bmb_pkg::RegFrameWidth, 9'd0);
        set_reg(bmb_pkg::RegFrameHeight, 9'd300);
        set_reg(bmb_pkg::RegRadiusX, 9'h1FF);
        set_reg(bmb_pkg::RegRadiusY, 9'h1F8);
        add_store(0, 0, 8'h55);
        add_read(0, 0);
        add_read(255, 255);
        drain();

        set_reg(bmb_pkg::RegFrameWidth, 9'd511);
        set_reg(bmb_pkg::RegFrameHeight, 9'd256);
        set_reg(bmb_pkg::RegRadiusX, 9'h100);
        set_reg(bmb_pkg::RegRadiusY, 9'h007);
        add_read(0, 0);
        add_read(255, 3);
        add_store(255, 0, 8'h80);
        add_read(17, 255);
        drain();

        // A full-size window around the hot spot stores the whole patch near
        // the origin, so later reads there need no extra stores.
        set_reg(bmb_pkg::RegFrameWidth, 9'd256);
        set_reg(bmb_pkg::RegFrameHeight, 9'd256);
        set_reg(bmb_pkg::RegRadiusX, 9'd7);
        set_reg(bmb_pkg::RegRadiusY, 9'd7);
        calm = 1'b1;
        add_read(HotSpan, HotSpan);
        drain();

        for (int p = 0; p < RandomPhases; p++) begin
            set_reg(bmb_pkg::RegFrameWidth, pick_dim());
            set_reg(bmb_pkg::RegFrameHeight, pick_dim());
            set_reg(bmb_pkg::RegRadiusX, 9'($urandom_range(511)));
            set_reg(bmb_pkg::RegRadiusY, 9'($urandom_range(511)));
            if (p == RandomPhases - 1) begin
                set_reg(bmb_pkg::RegRadiusX, 9'd7);
                set_reg(bmb_pkg::RegRadiusY, 9'd7);
            end
            calm = (p == 2);
            for (int n = 0; n < OpsPerPhase; n++) begin
                k = $urandom_range(99);
                c = $urandom_range(255);
                r = $urandom_range(255);
                if (k < 45 || (k >= 92 && on_frame(c, r)))
                    add_read($urandom_range(HotSpan), $urandom_range(HotSpan));
                else if (k < 80)
                    add_store($urandom_range(2 * HotSpan), $urandom_range(2 * HotSpan),
                              8'($urandom_range(255)));
                else if (k < 92)
                    add_store(c, r, 8'($urandom_range(255)));
                else
                    add_read(c, r);
            end
            drain();
        end

        if (mismatch_cnt == 0 && mean_backlog.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
                drv_item = cmd_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {drv_item.level, drv_item.row, drv_item.col};
                s_axis_tuser <= drv_item.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (mean_backlog.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Unexpected mean item: got %0d", m_axis_tdata);
                end else begin
                    want_mean = mean_backlog.pop_front();
                    if (m_axis_tdata !== want_mean) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("Mean mismatch: expected %0d, got %0d",
                                     want_mean, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == bmb_pkg::CmdRead)
                    mean_backlog.push_back(window_mean(s_axis_tdata[7:0], s_axis_tdata[15:8]));
                else if (on_frame(s_axis_tdata[7:0], s_axis_tdata[15:8]))
                    pix_mem[s_axis_tdata[15:8] * bmb_pkg::MaxWidth + s_axis_tdata[7:0]] =
                        s_axis_tdata[23:16];
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
rtl/bmb_pkg.sv
rtl/bmb_front.sv
rtl/bmb_queue.sv
rtl/bmb_back.sv
rtl/box_mean_blur_edge_clipped.sv
tb/testbench.sv
